// ===== sv/spn_pkg.sv =====
// Shared types, register map and lookup functions for the 16-bit SPN cipher.
`default_nettype none

package spn_pkg;

    // Register map: index = paddr[4:3], one 64-bit slot per register
    typedef enum logic [1:0] {
        REG_KEY   = 2'd0,
        REG_SBOX  = 2'd1,
        REG_ISBOX = 2'd2,
        REG_PERM  = 2'd3
    } t_reg_idx;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned BLOCK_W = 16;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned TABLE_W = 64;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TABLE_W-1:0] sbox;
        logic [TABLE_W-1:0] isbox;
        logic [TABLE_W-1:0] perm;
    } t_cfg;

    // Round key r: key bits (31-4r) down to (16-4r)
    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                     input int unsigned r);
        logic [KEY_W-1:0] sh;
        sh = key >> (16 - 4 * r);
        return sh[BLOCK_W-1:0];
    endfunction

    // Apply a 4-bit lookup table to every nibble
    function automatic logic [BLOCK_W-1:0] subst(input logic [BLOCK_W-1:0] x,
                                                 input logic [TABLE_W-1:0] tbl);
        logic [BLOCK_W-1:0] y;
        logic [3:0]         nib;
        y = '0;
        for (int n = 0; n < 4; n++) begin
            nib          = x[4*n +: 4];
            y[4*n +: 4]  = tbl[{nib, 2'b00} +: 4];
        end
        return y;
    endfunction

    // Bit permutation, positions counted from the MSB; colliding bits OR together
    function automatic logic [BLOCK_W-1:0] permute(input logic [BLOCK_W-1:0] x,
                                                   input logic [TABLE_W-1:0] perm);
        logic [BLOCK_W-1:0] y;
        logic [3:0]         dst;
        y = '0;
        for (int i = 0; i < 16; i++) begin
            dst             = perm[4*i +: 4];
            y[4'd15 - dst]  = y[4'd15 - dst] | x[15 - i];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== sv/spn_regs.sv =====
// APB configuration registers: key, S-box, inverse S-box, bit permutation.
`default_nettype none

module spn_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [spn_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [spn_pkg::DATA_W-1:0]   pwdata,
    output logic      [spn_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output spn_pkg::t_cfg                     o_cfg
);

    spn_pkg::t_cfg     r_cfg;
    spn_pkg::t_reg_idx idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = spn_pkg::t_reg_idx'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                spn_pkg::REG_KEY:   r_cfg.key   <= pwdata[spn_pkg::KEY_W-1:0];
                spn_pkg::REG_SBOX:  r_cfg.sbox  <= pwdata;
                spn_pkg::REG_ISBOX: r_cfg.isbox <= pwdata;
                spn_pkg::REG_PERM:  r_cfg.perm  <= pwdata;
                default:            r_cfg       <= r_cfg;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            spn_pkg::REG_KEY:   prdata = {{(spn_pkg::DATA_W-spn_pkg::KEY_W){1'b0}}, r_cfg.key};
            spn_pkg::REG_SBOX:  prdata = r_cfg.sbox;
            spn_pkg::REG_ISBOX: prdata = r_cfg.isbox;
            spn_pkg::REG_PERM:  prdata = r_cfg.perm;
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/spn_round.sv =====
// One middle round: nibble substitution, bit permutation, key mix.
`default_nettype none

module spn_round (
    input  wire logic [spn_pkg::BLOCK_W-1:0] i_x,
    input  wire logic [spn_pkg::TABLE_W-1:0] i_sbox,
    input  wire logic [spn_pkg::TABLE_W-1:0] i_perm,
    input  wire logic [spn_pkg::BLOCK_W-1:0] i_rkey,
    output logic      [spn_pkg::BLOCK_W-1:0] o_x
);

    logic [spn_pkg::BLOCK_W-1:0] sub_x;

    assign sub_x = spn_pkg::subst(i_x, i_sbox);
    assign o_x   = spn_pkg::permute(sub_x, i_perm) ^ i_rkey;

endmodule

`default_nettype wire

// ===== sv/spn_block_cipher_16bit.sv =====
// Top level of the 16-bit SPN block cipher: input register, rounds, result register.
//
// Usage:
//   Configure cipher_key (0x00), sbox_table (0x08), inverse_sbox_table (0x10)
//   and bit_permutation (0x18) over the APB port while no block is in flight.
//   A block beat is taken on each edge where i_start is high and o_busy is low;
//   o_busy is held low, so one block can enter every cycle.
//   i_action selects encrypt (0) or decrypt (1); i_data_block is the block.
// The block is captured in the input register, all ROUNDS rounds run in
//   one combinational pass, and o_result_block is shown with o_valid for
//   exactly one cycle on the cycle after.
// Throughput: 1 block per cycle, set by the single-pass round chain.
// Reset (synchronous, active low) clears all configuration registers to
//   zero and drops any block in flight; no strobe follows a reset.
// The receiver cannot stall: each result is present for one cycle only.
`default_nettype none

module spn_block_cipher_16bit #(
    parameter int unsigned ROUNDS = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_action,
    input  wire logic [spn_pkg::BLOCK_W-1:0]  i_data_block,
    output logic                              o_valid,
    output logic      [spn_pkg::BLOCK_W-1:0]  o_result_block,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [spn_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [spn_pkg::DATA_W-1:0]   pwdata,
    output logic      [spn_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int unsigned BW = spn_pkg::BLOCK_W;

    spn_pkg::t_cfg cfg;

    logic          r_in_vld;
    logic          r_action;
    logic [BW-1:0] r_data;
    logic          r_out_vld;
    logic [BW-1:0] r_result;
    logic [BW-1:0] n_result;

    logic [spn_pkg::TABLE_W-1:0] tbl;
    logic [BW-1:0]               key_first;
    logic [BW-1:0]               key_last;
    logic [BW-1:0]               rk_mid [1:ROUNDS-1];
    logic [BW-1:0]               x_chain [0:ROUNDS-1];

    spn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_busy = 1'b0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_action <= i_action;
            r_data   <= i_data_block;
        end
    end

    // Key schedule and table select; decrypt runs the equivalent inverse form
    assign tbl       = r_action ? cfg.isbox : cfg.sbox;
    assign key_first = r_action ? spn_pkg::round_key(cfg.key, ROUNDS)
                                : spn_pkg::round_key(cfg.key, 0);
    assign key_last  = r_action ? spn_pkg::round_key(cfg.key, 0)
                                : spn_pkg::round_key(cfg.key, ROUNDS);

    assign x_chain[0] = r_data ^ key_first;

    for (genvar g = 1; g < ROUNDS; g++) begin : g_round
        assign rk_mid[g] = r_action
            ? spn_pkg::permute(spn_pkg::round_key(cfg.key, ROUNDS - g), cfg.perm)
            : spn_pkg::round_key(cfg.key, g);

        spn_round u_round (
            .i_x    (x_chain[g-1]),
            .i_sbox (tbl),
            .i_perm (cfg.perm),
            .i_rkey (rk_mid[g]),
            .o_x    (x_chain[g])
        );
    end

    // Final substitution and key mix
    assign n_result = spn_pkg::subst(x_chain[ROUNDS-1], tbl) ^ key_last;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_block = r_result;

endmodule

`default_nettype wire

// ===== sv/spn_chk.sv =====
// Port-level checker for the SPN cipher, bound to the top level.
`default_nettype none

module spn_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_valid,
    input wire logic pready
);

    // Every accepted beat yields a strobe once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_valid)
        else $error("accepted beat without result");

    // No strobe without an accepted beat ahead of it in the input and result registers
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without accepted beat");

    // Reset drops anything in flight
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("strobe right after reset");

    // Block never stalls the sender or the configuration port
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy && pready)
        else $error("busy or pready dropped");

endmodule

bind spn_block_cipher_16bit spn_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .pready  (pready)
);

`default_nettype wire

// ===== test/spn_block_cipher_16bit_tb.sv =====
// Self-checking testbench for the 16-bit SPN block cipher: APB setup, block beats, result check.
module spn_block_cipher_16bit_tb;

    localparam int unsigned ROUNDS     = 4;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_PAD  = 3;

    // Action codes on i_action
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // Textbook tables: S-box entry n at nibble n, and the identity table
    localparam logic [63:0] HEYS_SBOX = 64'h7095C6A38BF21D4E;
    localparam logic [63:0] IDENT_TBL = 64'hFEDCBA9876543210;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_start      = 1'b0;
    logic        i_action     = 1'b0;
    logic [15:0] i_data_block = '0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [spn_pkg::ADDR_W-1:0] paddr  = '0;
    logic [spn_pkg::DATA_W-1:0] pwdata = '0;
    logic        o_busy;
    logic        o_valid;
    logic [15:0] o_result_block;
    logic [spn_pkg::DATA_W-1:0] prdata;
    logic        pready;

    // Local copy of the programmed registers
    logic [31:0] cfg_key   = '0;
    logic [63:0] cfg_sbox  = '0;
    logic [63:0] cfg_isbox = '0;
    logic [63:0] cfg_perm  = '0;

    logic [15:0] expected_blocks[$];
    logic [15:0] oldest_block;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    spn_block_cipher_16bit #(.ROUNDS(ROUNDS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_data_block   (i_data_block),
        .o_valid        (o_valid),
        .o_result_block (o_result_block),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- cipher prediction ----------------

    function automatic logic [15:0] key_slice(input int unsigned r);
        logic [31:0] sh;
        sh = cfg_key >> (16 - 4 * r);
        return sh[15:0];
    endfunction

    function automatic logic [15:0] sub_nibbles(input logic [15:0] x, input logic [63:0] tbl);
        logic [15:0] y;
        int unsigned v;
        y = '0;
        for (int n = 0; n < 4; n++) begin
            v = 32'(x[4*n +: 4]);
            y[4*n +: 4] = tbl[4*v +: 4];
        end
        return y;
    endfunction

    // Bits counted from the MSB; several sources on one destination are ORed
    function automatic logic [15:0] scatter_bits(input logic [15:0] x);
        logic [15:0] y;
        int unsigned dst;
        y = '0;
        for (int i = 0; i < 16; i++) begin
            dst = 32'(cfg_perm[4*i +: 4]);
            y[15 - dst] = y[15 - dst] | x[15 - i];
        end
        return y;
    endfunction

    function automatic logic [15:0] predict_block(input logic act, input logic [15:0] blk);
        logic [15:0] x;
        x = blk;
        if (act == ACT_ENCRYPT) begin
            x = x ^ key_slice(0);
            for (int r = 1; r < ROUNDS; r++) begin
                x = scatter_bits(sub_nibbles(x, cfg_sbox)) ^ key_slice(r);
            end
            x = sub_nibbles(x, cfg_sbox) ^ key_slice(ROUNDS);
        end else begin
            x = x ^ key_slice(ROUNDS);
            for (int r = ROUNDS - 1; r > 0; r--) begin
                x = scatter_bits(sub_nibbles(x, cfg_isbox)) ^ scatter_bits(key_slice(r));
            end
            x = sub_nibbles(x, cfg_isbox) ^ key_slice(0);
        end
        return x;
    endfunction

    // ---------------- table builders ----------------

    function automatic logic [63:0] invert_table(input logic [63:0] tbl);
        logic [63:0] inv;
        int unsigned v;
        inv = '0;
        for (int n = 0; n < 16; n++) begin
            v = 32'(tbl[4*n +: 4]);
            inv[4*v +: 4] = n[3:0];
        end
        return inv;
    endfunction

    function automatic logic [63:0] random_bijection();
        logic [63:0] t;
        logic [3:0]  tmp;
        int unsigned j;
        t = IDENT_TBL;
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = t[4*i +: 4];
            t[4*i +: 4] = t[4*j +: 4];
            t[4*j +: 4] = tmp;
        end
        return t;
    endfunction

    // Random pairing of bit positions, so the permutation is its own inverse
    function automatic logic [63:0] random_involution();
        logic [63:0] p;
        logic [15:0] used;
        int unsigned j;
        p = '0;
        used = '0;
        for (int i = 0; i < 16; i++) begin
            if (!used[i]) begin
                do j = $urandom_range(i, 15); while (used[j]);
                p[4*i +: 4] = j[3:0];
                p[4*j +: 4] = i[3:0];
                used[i] = 1'b1;
                used[j] = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] transpose_perm();
        logic [63:0] p;
        int unsigned d;
        for (int i = 0; i < 16; i++) begin
            d = 4 * (i % 4) + i / 4;
            p[4*i +: 4] = d[3:0];
        end
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one; none while no_gaps is set
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_block();
        logic [15:0] one_hot;
        one_hot = 16'h1 << $urandom_range(0, 15);
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ---------------- bus and beat tasks ----------------

    task automatic write_reg(input spn_pkg::t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spn_pkg::REG_KEY:   cfg_key   = value[31:0];
            spn_pkg::REG_SBOX:  cfg_sbox  = value;
            spn_pkg::REG_ISBOX: cfg_isbox = value;
            spn_pkg::REG_PERM:  cfg_perm  = value;
            default: ;
        endcase
        // The bus returns to idle between writes
        @(posedge i_clk);
    endtask

    // Upper key bits carry noise; only the low 32 are kept
    task automatic load_config(input logic [31:0] key, input logic [63:0] sbox,
                               input logic [63:0] isbox, input logic [63:0] perm);
        write_reg(spn_pkg::REG_KEY, {$urandom, key});
        write_reg(spn_pkg::REG_SBOX, sbox);
        write_reg(spn_pkg::REG_ISBOX, isbox);
        write_reg(spn_pkg::REG_PERM, perm);
    endtask

    // One block beat; start stays high into the next beat when no gap follows
    task automatic send_block(input logic act, input logic [15:0] blk);
        int unsigned gap;
        i_start      <= 1'b1;
        i_action     <= act;
        i_data_block <= blk;
        do @(posedge i_clk); while (o_busy);
        gap = pick_gap();
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_blocks.size() != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Encrypt a block, then decrypt the predicted ciphertext
    task automatic send_round_trip(input logic [15:0] plain);
        send_block(ACT_ENCRYPT, plain);
        send_block(ACT_DECRYPT, predict_block(ACT_ENCRYPT, plain));
    endtask

    // ---------------- tests ----------------

    // All registers at zero after reset
    task automatic test_reset_values();
        send_block(ACT_ENCRYPT, 16'h0000);
        send_block(ACT_DECRYPT, 16'hFFFF);
        wait_idle();
    endtask

    // Textbook tables: extreme blocks in both directions, single-bit blocks encrypted
    task automatic test_textbook_extremes();
        load_config(32'hA5C3_0FF0, HEYS_SBOX, invert_table(HEYS_SBOX), transpose_perm());
        send_block(ACT_ENCRYPT, 16'h0000);
        send_block(ACT_ENCRYPT, 16'hFFFF);
        send_block(ACT_ENCRYPT, 16'h8000);
        send_block(ACT_ENCRYPT, 16'h0001);
        send_block(ACT_DECRYPT, 16'h0000);
        send_block(ACT_DECRYPT, 16'hFFFF);
        send_round_trip(16'h1234);
        wait_idle();
    endtask

    task automatic test_key_extremes();
        write_reg(spn_pkg::REG_KEY, 64'h0);
        send_block(ACT_ENCRYPT, 16'h5A5A);
        send_block(ACT_DECRYPT, 16'hA5A5);
        wait_idle();
        write_reg(spn_pkg::REG_KEY, {32'h0, 32'hFFFF_FFFF});
        send_block(ACT_ENCRYPT, 16'h5A5A);
        send_block(ACT_DECRYPT, 16'hA5A5);
        wait_idle();
    endtask

    // All bits onto one destination: MSB, then LSB
    task automatic test_collapsed_perm();
        write_reg(spn_pkg::REG_PERM, 64'h0);
        send_block(ACT_ENCRYPT, 16'hC3C3);
        send_block(ACT_DECRYPT, 16'h3C3C);
        wait_idle();
        write_reg(spn_pkg::REG_PERM, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(spn_pkg::REG_SBOX, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(spn_pkg::REG_ISBOX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(ACT_ENCRYPT, 16'hC3C3);
        send_block(ACT_DECRYPT, 16'h3C3C);
        wait_idle();
    endtask

    // Rotating permutation and inverse table equal to the forward one
    task automatic test_non_involution();
        load_config(32'h1357_9BDF, HEYS_SBOX, HEYS_SBOX, {IDENT_TBL[59:0], IDENT_TBL[63:60]});
        send_round_trip(16'hBEEF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [63:0] sbox;
        int unsigned sent;
        for (int set = 0; set < 8; set++) begin
            case (set % 4)
                0: load_config($urandom, HEYS_SBOX, invert_table(HEYS_SBOX), transpose_perm());
                1: begin
                    sbox = random_bijection();
                    load_config($urandom, sbox, invert_table(sbox), random_involution());
                end
                2: begin
                    sbox = random_bijection();
                    load_config($urandom, sbox, invert_table(sbox), random_bijection());
                end
                default: load_config($urandom, rand64(), rand64(), rand64());
            endcase
            no_gaps = (set % 3 == 2);
            sent = 0;
            while (sent < 128) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_round_trip(pick_block());
                    sent += 2;
                end else begin
                    send_block(1'($urandom_range(0, 1)), pick_block());
                    sent += 1;
                end
            end
            no_gaps = 1'b0;
            wait_idle();
        end
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            expected_blocks.push_back(predict_block(i_action, i_data_block));
        end
        if (i_rst_n && o_valid) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h",
                         $time, o_result_block);
                mismatches++;
            end else begin
                oldest_block = expected_blocks.pop_front();
                if (o_result_block !== oldest_block) begin
                    $display("%0t: result_block mismatch: expected %h, actual %h",
                             $time, oldest_block, o_result_block);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat of any kind
    always @(posedge i_clk) begin
        if ((i_rst_n && i_start && !o_busy) || (i_rst_n && o_valid) ||
            (psel && penable && pready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_textbook_extremes();
        test_key_extremes();
        test_collapsed_perm();
        test_non_involution();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
